### src/ltsr_pkg.sv
// Shared types and constants for the light tracking servo ramp.
`default_nettype none

package ltsr_pkg;

    localparam int SAMPLE_W = 12;
    localparam int PULSE_W  = 12;
    localparam int ANGLE_W  = 8;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 4;
    localparam int STEP_W   = 4;
    localparam int TICK_W   = 8;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
    localparam logic [PULSE_W-1:0] POS_RESET = 12'd750;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_CENTER = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTVL  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_TICKS  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TICKS  = 4'd7;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_TRACK = 2'd1,
        ACT_ANGLE = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TRACK = 2'd1,
        MODE_ANGLE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STOP_NONE     = 2'd0,
        STOP_REACHED  = 2'd1,
        STOP_SPLIT    = 2'd2,
        STOP_BALANCED = 2'd3
    } stop_t;

    typedef enum logic [1:0] {
        AMAP_SCALE  = 2'd0,
        AMAP_DIVIDE = 2'd1,
        AMAP_DONE   = 2'd2
    } amap_phase_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] tolerance;
        logic [SAMPLE_W-1:0] light_threshold;
        logic [PULSE_W-1:0]  pulse_min;
        logic [PULSE_W-1:0]  pulse_max;
        logic [PULSE_W-1:0]  pulse_center;
        logic [STEP_W-1:0]   check_interval;
        logic [TICK_W-1:0]   track_step_ticks;
        logic [TICK_W-1:0]   angle_step_ticks;
    } cfg_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pwm_compare;
        logic               busy_res;
        logic               indicator_a;
        logic               indicator_b;
        stop_t              stop_cause;
    } res_t;

    // Product of angle and span is below 2^20; floor(2^20 / 180) gives a
    // quotient estimate that is low by at most one.
    localparam int PROD_W  = ANGLE_W + PULSE_W;
    localparam int RECIP_W = 13;
    localparam int RECIP_SHIFT = 20;
    localparam logic [RECIP_W-1:0] RECIP_180 = 13'd5825;
    localparam logic [PROD_W-1:0]  DIV_180   = 20'd180;

endpackage

`default_nettype wire

### src/ltsr_cfg_regs.sv
// Configuration register file with write decode and reset defaults.
`default_nettype none

module ltsr_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [ltsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ltsr_pkg::CFG_W-1:0]       cfg_wr_data,
    output ltsr_pkg::cfg_t                        cfg
);

    ltsr_pkg::cfg_t cfg_reg;
    ltsr_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                ltsr_pkg::REG_TOLERANCE:    cfg_next.tolerance = cfg_wr_data;
                ltsr_pkg::REG_THRESHOLD:    cfg_next.light_threshold = cfg_wr_data;
                ltsr_pkg::REG_PULSE_MIN:    cfg_next.pulse_min = cfg_wr_data;
                ltsr_pkg::REG_PULSE_MAX:    cfg_next.pulse_max = cfg_wr_data;
                ltsr_pkg::REG_PULSE_CENTER: cfg_next.pulse_center = cfg_wr_data;
                ltsr_pkg::REG_CHECK_INTVL: begin
                    cfg_next.check_interval = cfg_wr_data[ltsr_pkg::STEP_W-1:0];
                end
                ltsr_pkg::REG_TRACK_TICKS: begin
                    cfg_next.track_step_ticks = cfg_wr_data[ltsr_pkg::TICK_W-1:0];
                end
                ltsr_pkg::REG_ANGLE_TICKS: begin
                    cfg_next.angle_step_ticks = cfg_wr_data[ltsr_pkg::TICK_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tolerance        <= 12'd20;
            cfg_reg.light_threshold  <= 12'd2048;
            cfg_reg.pulse_min        <= 12'd250;
            cfg_reg.pulse_max        <= 12'd1250;
            cfg_reg.pulse_center     <= 12'd750;
            cfg_reg.check_interval   <= 4'd10;
            cfg_reg.track_step_ticks <= 8'd1;
            cfg_reg.angle_step_ticks <= 8'd10;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### src/ltsr_angle_map.sv
// Three-phase angle to compare value mapper: scale, divide by 180, offset.
`default_nettype none

module ltsr_angle_map (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire ltsr_pkg::cfg_t                  cfg,
    input  wire logic                            active,
    input  wire logic                            can_out,
    input  wire logic [ltsr_pkg::ANGLE_W-1:0]    angle,
    output logic                                 done,
    output logic [ltsr_pkg::PULSE_W-1:0]         target
);

    localparam int PW = ltsr_pkg::PROD_W;
    localparam int QW = ltsr_pkg::PULSE_W;
    localparam int EW = PW + ltsr_pkg::RECIP_W;

    ltsr_pkg::amap_phase_t phase_reg, phase_next;

    logic [PW-1:0]  prod_reg, prod_next;
    logic           down_reg, down_next;
    logic [QW-1:0]  quot_reg, quot_next;

    logic [ltsr_pkg::ANGLE_W-1:0] angle_clamped;
    logic [QW-1:0]  span;
    logic [EW-1:0]  est_full;
    logic [PW-1:0]  remainder;
    logic [QW-1:0]  quot_fixed;

    always_comb begin
        phase_next = phase_reg;
        if (active) begin
            unique case (phase_reg)
                ltsr_pkg::AMAP_SCALE:  phase_next = ltsr_pkg::AMAP_DIVIDE;
                ltsr_pkg::AMAP_DIVIDE: phase_next = ltsr_pkg::AMAP_DONE;
                ltsr_pkg::AMAP_DONE: begin
                    if (can_out) begin
                        phase_next = ltsr_pkg::AMAP_SCALE;
                    end
                end
                default: phase_next = ltsr_pkg::AMAP_SCALE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ltsr_pkg::AMAP_SCALE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Scale phase: clamp the angle and multiply by the pulse span.
    always_comb begin
        angle_clamped = (angle > ltsr_pkg::ANGLE_MAX) ? ltsr_pkg::ANGLE_MAX : angle;
        down_next     = cfg.pulse_max < cfg.pulse_min;
        span          = down_next ? (cfg.pulse_min - cfg.pulse_max)
                                  : (cfg.pulse_max - cfg.pulse_min);
        prod_next     = PW'(angle_clamped) * PW'(span);
    end

    // Divide phase: reciprocal multiply gives the quotient or one less.
    always_comb begin
        est_full  = EW'(prod_reg) * EW'(ltsr_pkg::RECIP_180);
        quot_next = est_full[ltsr_pkg::RECIP_SHIFT +: QW];
    end

    always_ff @(posedge aclk) begin
        if (active && (phase_reg == ltsr_pkg::AMAP_SCALE)) begin
            prod_reg <= prod_next;
            down_reg <= down_next;
        end
        if (active && (phase_reg == ltsr_pkg::AMAP_DIVIDE)) begin
            quot_reg <= quot_next;
        end
    end

    // Final phase: correct the estimate and apply it from pulse_min.
    always_comb begin
        remainder  = prod_reg - PW'(quot_reg) * ltsr_pkg::DIV_180;
        quot_fixed = quot_reg + QW'(remainder >= ltsr_pkg::DIV_180);
        target     = down_reg ? (cfg.pulse_min - quot_fixed)
                              : (cfg.pulse_min + quot_fixed);
        done       = phase_reg == ltsr_pkg::AMAP_DONE;
    end

endmodule

`default_nettype wire

### src/ltsr_ramp_core.sv
// Ramp state, item decode and the per-item state update.
`default_nettype none

module ltsr_ramp_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire ltsr_pkg::cfg_t                   cfg,
    input  wire logic                             fire,
    input  wire ltsr_pkg::act_t                   action,
    input  wire logic [ltsr_pkg::SAMPLE_W-1:0]    light_a,
    input  wire logic [ltsr_pkg::SAMPLE_W-1:0]    light_b,
    input  wire logic [ltsr_pkg::PULSE_W-1:0]     angle_target,
    output ltsr_pkg::res_t                        res
);

    localparam int PW = ltsr_pkg::PULSE_W;
    localparam int SW = ltsr_pkg::SAMPLE_W;

    logic [PW-1:0]                   position_reg, position_next;
    logic [PW-1:0]                   goal_reg, goal_next;
    ltsr_pkg::mode_t                 mode_reg, mode_next;
    logic [ltsr_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [ltsr_pkg::TICK_W-1:0]     presc_reg, presc_next;
    logic                            ind_a_reg, ind_a_next;
    logic                            ind_b_reg, ind_b_next;

    logic                            ramping;
    logic                            hi_a, hi_b;
    logic [SW-1:0]                   diff;
    logic [ltsr_pkg::TICK_W-1:0]     step_ticks;
    logic [ltsr_pkg::TICK_W-1:0]     presc_inc;
    logic [ltsr_pkg::STEP_W-1:0]     step_inc;
    logic [PW-1:0]                   track_target;
    ltsr_pkg::stop_t                 cause;

    always_comb begin
        ramping      = (mode_reg == ltsr_pkg::MODE_TRACK) ||
                       (mode_reg == ltsr_pkg::MODE_ANGLE);
        hi_a         = light_a > cfg.light_threshold;
        hi_b         = light_b > cfg.light_threshold;
        diff         = (light_a > light_b) ? (light_a - light_b) : (light_b - light_a);
        step_ticks   = (mode_reg == ltsr_pkg::MODE_TRACK) ? cfg.track_step_ticks
                                                         : cfg.angle_step_ticks;
        presc_inc    = presc_reg + 1'b1;
        step_inc     = step_reg + 1'b1;
        if (light_a > light_b) begin
            track_target = cfg.pulse_min;
        end else if (light_a < light_b) begin
            track_target = cfg.pulse_max;
        end else begin
            track_target = cfg.pulse_center;
        end

        position_next = position_reg;
        goal_next     = goal_reg;
        mode_next     = mode_reg;
        step_next     = step_reg;
        presc_next    = presc_reg;
        ind_a_next    = ind_a_reg;
        ind_b_next    = ind_b_reg;
        cause         = ltsr_pkg::STOP_NONE;

        if (fire) begin
            unique case (action)
                ltsr_pkg::ACT_TICK: begin
                    if (ramping) begin
                        if (presc_inc < step_ticks) begin
                            presc_next = presc_inc;
                        end else begin
                            presc_next = '0;
                            if (position_reg < goal_reg) begin
                                position_next = position_reg + 1'b1;
                            end else if (position_reg > goal_reg) begin
                                position_next = position_reg - 1'b1;
                            end
                            if (mode_reg == ltsr_pkg::MODE_TRACK) begin
                                if (step_inc >= cfg.check_interval) begin
                                    step_next = '0;
                                    // Split light takes precedence over balance.
                                    if (hi_a != hi_b) begin
                                        cause = ltsr_pkg::STOP_SPLIT;
                                    end else if (diff <= cfg.tolerance) begin
                                        cause = ltsr_pkg::STOP_BALANCED;
                                    end
                                end else begin
                                    step_next = step_inc;
                                end
                            end
                            if ((cause == ltsr_pkg::STOP_NONE) &&
                                (position_next == goal_reg)) begin
                                cause = ltsr_pkg::STOP_REACHED;
                            end
                            if (cause != ltsr_pkg::STOP_NONE) begin
                                mode_next  = ltsr_pkg::MODE_IDLE;
                                step_next  = '0;
                                presc_next = '0;
                            end
                        end
                    end
                end
                ltsr_pkg::ACT_TRACK: begin
                    if (mode_reg == ltsr_pkg::MODE_IDLE) begin
                        ind_a_next = !hi_a;
                        ind_b_next = !hi_b;
                        if (diff >= cfg.tolerance) begin
                            goal_next = track_target;
                            if (track_target != position_reg) begin
                                mode_next  = ltsr_pkg::MODE_TRACK;
                                step_next  = '0;
                                presc_next = '0;
                            end
                        end
                    end
                end
                ltsr_pkg::ACT_ANGLE: begin
                    if (mode_reg == ltsr_pkg::MODE_IDLE) begin
                        goal_next = angle_target;
                        if (angle_target != position_reg) begin
                            mode_next  = ltsr_pkg::MODE_ANGLE;
                            step_next  = '0;
                            presc_next = '0;
                        end
                    end
                end
                default: ;
            endcase
        end

        res.pwm_compare = position_next;
        res.busy_res    = mode_next != ltsr_pkg::MODE_IDLE;
        res.indicator_a = ind_a_next;
        res.indicator_b = ind_b_next;
        res.stop_cause  = cause;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= ltsr_pkg::POS_RESET;
            goal_reg     <= '0;
            mode_reg     <= ltsr_pkg::MODE_IDLE;
            step_reg     <= '0;
            presc_reg    <= '0;
            ind_a_reg    <= 1'b0;
            ind_b_reg    <= 1'b0;
        end else begin
            position_reg <= position_next;
            goal_reg     <= goal_next;
            mode_reg     <= mode_next;
            step_reg     <= step_next;
            presc_reg    <= presc_next;
            ind_a_reg    <= ind_a_next;
            ind_b_reg    <= ind_b_next;
        end
    end

endmodule

`default_nettype wire

### src/light_tracking_servo_ramp.sv
// A tick or tracking item passes from the input register to the output register;
// an angle item also passes the angle mapper's scale, divide and done phases.
// Throughput: one item per cycle unless results stall; an angle item holds the
// input register through scale multiply, reciprocal multiply and correction.
// Reset: synchronous, active low; registers return to their defaults and the
// position to 750, both channels empty. No clearing pass is needed.
`default_nettype none

module light_tracking_servo_ramp (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [ltsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ltsr_pkg::CFG_W-1:0]       cfg_wr_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_action,
    input  wire logic [ltsr_pkg::SAMPLE_W-1:0]    s_light_a,
    input  wire logic [ltsr_pkg::SAMPLE_W-1:0]    s_light_b,
    input  wire logic [ltsr_pkg::ANGLE_W-1:0]     s_angle,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [ltsr_pkg::PULSE_W-1:0]          m_pwm_compare,
    output logic                                  m_busy_res,
    output logic                                  m_indicator_a,
    output logic                                  m_indicator_b,
    output logic [1:0]                            m_stop_cause
);

    ltsr_pkg::cfg_t cfg;

    logic                               in_valid_reg, in_valid_next;
    ltsr_pkg::act_t                     in_action_reg;
    logic [ltsr_pkg::SAMPLE_W-1:0]      in_light_a_reg;
    logic [ltsr_pkg::SAMPLE_W-1:0]      in_light_b_reg;
    logic [ltsr_pkg::ANGLE_W-1:0]       in_angle_reg;

    logic                               out_valid_reg, out_valid_next;
    ltsr_pkg::res_t                     out_res_reg;

    logic                               in_xfer;
    logic                               can_out;
    logic                               is_angle;
    logic                               ang_done;
    logic                               in_fire;
    logic [ltsr_pkg::PULSE_W-1:0]       angle_target;
    ltsr_pkg::res_t                     core_res;

    ltsr_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    ltsr_angle_map u_angle (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .active  (in_valid_reg && is_angle),
        .can_out (can_out),
        .angle   (in_angle_reg),
        .done    (ang_done),
        .target  (angle_target)
    );

    ltsr_ramp_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .fire         (in_fire),
        .action       (in_action_reg),
        .light_a      (in_light_a_reg),
        .light_b      (in_light_b_reg),
        .angle_target (angle_target),
        .res          (core_res)
    );

    always_comb begin
        is_angle = in_action_reg == ltsr_pkg::ACT_ANGLE;
        can_out  = !out_valid_reg || m_ready;
        in_fire  = in_valid_reg && can_out && (!is_angle || ang_done);
        s_ready  = !in_valid_reg || in_fire;
        in_xfer  = s_valid && s_ready;

        in_valid_next = in_xfer ? 1'b1 : (in_fire ? 1'b0 : in_valid_reg);
        out_valid_next = in_fire ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_action_reg  <= ltsr_pkg::act_t'(s_action);
            in_light_a_reg <= s_light_a;
            in_light_b_reg <= s_light_b;
            in_angle_reg   <= s_angle;
        end
        if (in_fire) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pwm_compare = out_res_reg.pwm_compare;
    assign m_busy_res    = out_res_reg.busy_res;
    assign m_indicator_a = out_res_reg.indicator_a;
    assign m_indicator_b = out_res_reg.indicator_b;
    assign m_stop_cause  = out_res_reg.stop_cause;

endmodule

`default_nettype wire

### tb/sv/ltsr_checker.sv
// Result checker for the light tracking servo ramp: predicts each result and compares it.
`timescale 1ns / 1ps

module ltsr_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ltsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ltsr_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic [1:0]                     s_action,
    input  wire logic [ltsr_pkg::SAMPLE_W-1:0]  s_light_a,
    input  wire logic [ltsr_pkg::SAMPLE_W-1:0]  s_light_b,
    input  wire logic [ltsr_pkg::ANGLE_W-1:0]   s_angle,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic [ltsr_pkg::PULSE_W-1:0]   m_pwm_compare,
    input  wire logic                           m_busy_res,
    input  wire logic                           m_indicator_a,
    input  wire logic                           m_indicator_b,
    input  wire logic [1:0]                     m_stop_cause,
    output int                                  mismatches,
    output int                                  outstanding
);

    import ltsr_pkg::*;

    cfg_t               cfg;
    logic [PULSE_W-1:0] position;
    logic [PULSE_W-1:0] goal;
    mode_t              ramp;
    logic [STEP_W-1:0]  ramp_steps;
    logic [TICK_W-1:0]  prescale;
    logic               ind_a;
    logic               ind_b;

    res_t predicted_outputs[$];

    // Applies one item to the servo state and returns the output it produces.
    function automatic res_t advance_servo(input logic [1:0] act,
                                           input logic [SAMPLE_W-1:0] la,
                                           input logic [SAMPLE_W-1:0] lb,
                                           input logic [ANGLE_W-1:0] ang);
        res_t                r;
        stop_t               cause;
        mode_t               launch;
        logic                was_busy;
        logic [TICK_W-1:0]   period;
        logic [PULSE_W-1:0]  target;
        logic [SAMPLE_W-1:0] diff;
        int                  deg;
        int                  span;
        int                  offs;
        cause    = STOP_NONE;
        launch   = MODE_IDLE;
        target   = cfg.pulse_center;
        was_busy = (ramp != MODE_IDLE);
        diff     = (la > lb) ? la - lb : lb - la;
        case (act)
            ACT_TICK: begin
                if (ramp != MODE_IDLE) begin
                    period   = (ramp == MODE_TRACK) ? cfg.track_step_ticks
                                                    : cfg.angle_step_ticks;
                    prescale = prescale + 1'b1;
                    // A period of zero behaves like one since the count is at least one here.
                    if (prescale >= period) begin
                        prescale = '0;
                        if (position < goal) begin
                            position = position + 1'b1;
                        end else if (position > goal) begin
                            position = position - 1'b1;
                        end
                        if (ramp == MODE_TRACK) begin
                            ramp_steps = ramp_steps + 1'b1;
                            if (ramp_steps >= cfg.check_interval) begin
                                ramp_steps = '0;
                                if ((la > cfg.light_threshold) != (lb > cfg.light_threshold)) begin
                                    cause = STOP_SPLIT;
                                end else if (diff <= cfg.tolerance) begin
                                    cause = STOP_BALANCED;
                                end
                            end
                        end
                        // A light check stop takes precedence over arriving at the goal.
                        if (cause == STOP_NONE && position == goal) begin
                            cause = STOP_REACHED;
                        end
                        if (cause != STOP_NONE) begin
                            ramp       = MODE_IDLE;
                            ramp_steps = '0;
                            prescale   = '0;
                        end
                    end
                end
            end
            ACT_TRACK: begin
                if (!was_busy) begin
                    ind_a = (la > cfg.light_threshold) ? 1'b0 : 1'b1;
                    ind_b = (lb > cfg.light_threshold) ? 1'b0 : 1'b1;
                    if (la > lb) begin
                        target = cfg.pulse_min;
                    end else if (la < lb) begin
                        target = cfg.pulse_max;
                    end
                    if (diff >= cfg.tolerance) begin
                        launch = MODE_TRACK;
                    end
                end
            end
            ACT_ANGLE: begin
                if (!was_busy) begin
                    deg = (ang > ANGLE_MAX) ? int'(ANGLE_MAX) : int'(ang);
                    if (cfg.pulse_max >= cfg.pulse_min) begin
                        span   = int'(cfg.pulse_max) - int'(cfg.pulse_min);
                        offs   = (deg * span) / int'(ANGLE_MAX);
                        target = PULSE_W'(int'(cfg.pulse_min) + offs);
                    end else begin
                        span   = int'(cfg.pulse_min) - int'(cfg.pulse_max);
                        offs   = (deg * span) / int'(ANGLE_MAX);
                        target = PULSE_W'(int'(cfg.pulse_min) - offs);
                    end
                    launch = MODE_ANGLE;
                end
            end
            default: begin
            end
        endcase
        if (launch != MODE_IDLE) begin
            goal = target;
            if (goal != position) begin
                ramp       = launch;
                ramp_steps = '0;
                prescale   = '0;
            end
        end
        r.pwm_compare = position;
        r.busy_res    = (ramp != MODE_IDLE);
        r.indicator_a = ind_a;
        r.indicator_b = ind_b;
        r.stop_cause  = cause;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        res_t want;
        res_t got;
        if (!aresetn) begin
            cfg.tolerance        = 12'd20;
            cfg.light_threshold  = 12'd2048;
            cfg.pulse_min        = 12'd250;
            cfg.pulse_max        = 12'd1250;
            cfg.pulse_center     = 12'd750;
            cfg.check_interval   = 4'd10;
            cfg.track_step_ticks = 8'd1;
            cfg.angle_step_ticks = 8'd10;
            position   = POS_RESET;
            goal       = '0;
            ramp       = MODE_IDLE;
            ramp_steps = '0;
            prescale   = '0;
            ind_a      = 1'b0;
            ind_b      = 1'b0;
            mismatches = 0;
            predicted_outputs.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.pwm_compare = m_pwm_compare;
                got.busy_res    = m_busy_res;
                got.indicator_a = m_indicator_a;
                got.indicator_b = m_indicator_b;
                got.stop_cause  = stop_t'(m_stop_cause);
                if (predicted_outputs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result transfer with nothing expected: pwm=%0d busy=%0b",
                                 $realtime, got.pwm_compare, got.busy_res);
                    end
                end else begin
                    want = predicted_outputs.pop_front();
                    if (want.pwm_compare != got.pwm_compare || want.busy_res != got.busy_res ||
                        want.indicator_a != got.indicator_a ||
                        want.indicator_b != got.indicator_b ||
                        want.stop_cause != got.stop_cause) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected pwm=%0d busy=%0b ind=%0b%0b stop=%0d",
                                     $realtime, want.pwm_compare, want.busy_res,
                                     want.indicator_a, want.indicator_b, want.stop_cause);
                            $display("%0t: actual   pwm=%0d busy=%0b ind=%0b%0b stop=%0d",
                                     $realtime, got.pwm_compare, got.busy_res,
                                     got.indicator_a, got.indicator_b, got.stop_cause);
                        end
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TOLERANCE:    cfg.tolerance        = cfg_wr_data;
                    REG_THRESHOLD:    cfg.light_threshold  = cfg_wr_data;
                    REG_PULSE_MIN:    cfg.pulse_min        = cfg_wr_data;
                    REG_PULSE_MAX:    cfg.pulse_max        = cfg_wr_data;
                    REG_PULSE_CENTER: cfg.pulse_center     = cfg_wr_data;
                    REG_CHECK_INTVL:  cfg.check_interval   = cfg_wr_data[STEP_W-1:0];
                    REG_TRACK_TICKS:  cfg.track_step_ticks = cfg_wr_data[TICK_W-1:0];
                    REG_ANGLE_TICKS:  cfg.angle_step_ticks = cfg_wr_data[TICK_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                predicted_outputs.push_back(advance_servo(s_action, s_light_a, s_light_b,
                                                          s_angle));
            end
        end
        outstanding = predicted_outputs.size();
    end

endmodule

### tb/sv/tb_top.sv
// Testbench top for the light tracking servo ramp: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module tb_top;

    import ltsr_pkg::*;

    localparam logic [1:0]           ACT_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_action    = '0;
    logic [SAMPLE_W-1:0]  s_light_a   = '0;
    logic [SAMPLE_W-1:0]  s_light_b   = '0;
    logic [ANGLE_W-1:0]   s_angle     = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [PULSE_W-1:0]   m_pwm_compare;
    logic                 m_busy_res;
    logic                 m_indicator_a;
    logic                 m_indicator_b;
    logic [1:0]           m_stop_cause;

    int mismatches;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cur_tol        = 20;
    int cur_thr        = 2048;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    light_tracking_servo_ramp u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_light_a     (s_light_a),
        .s_light_b     (s_light_b),
        .s_angle       (s_angle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pwm_compare (m_pwm_compare),
        .m_busy_res    (m_busy_res),
        .m_indicator_a (m_indicator_a),
        .m_indicator_b (m_indicator_b),
        .m_stop_cause  (m_stop_cause)
    );

    ltsr_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_light_a     (s_light_a),
        .s_light_b     (s_light_b),
        .s_angle       (s_angle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pwm_compare (m_pwm_compare),
        .m_busy_res    (m_busy_res),
        .m_indicator_a (m_indicator_a),
        .m_indicator_b (m_indicator_b),
        .m_stop_cause  (m_stop_cause),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Profiles: no idling, sender idle, receiver stalling, both lightly.
    task automatic set_profile(input int p);
        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
        endcase
    endtask

    task automatic send_item(input logic [1:0] act, input logic [SAMPLE_W-1:0] la,
                             input logic [SAMPLE_W-1:0] lb, input logic [ANGLE_W-1:0] ang);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= act;
        s_light_a <= la;
        s_light_b <= lb;
        s_angle   <= ang;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops sending and waits until every predicted result has been transferred.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= CFG_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_TOLERANCE) cur_tol = value;
        if (idx == REG_THRESHOLD) cur_thr = value;
    endtask

    function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
        if (v < 0) return '0;
        if (v > 4095) return 12'd4095;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] corner_sample();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return 12'd4095;
            2: return clamp_sample(cur_thr);
            default: return clamp_sample(cur_thr + 1);
        endcase
    endfunction

    task automatic send_random(input int count, input int profile_base);
        logic [1:0]         act;
        logic [ANGLE_W-1:0] ang;
        int                 pick;
        int                 a;
        int                 b;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) set_profile(profile_base + i / 100);
            // Halfway through, the sender holds off until the pipeline is empty.
            if (i == count / 2) drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 65) act = ACT_TICK;
            else if (pick < 81) act = ACT_TRACK;
            else if (pick < 95) act = ACT_ANGLE;
            else act = ACT_UNUSED;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    a = $urandom_range(0, 4095);
                    b = $urandom_range(0, 4095);
                end
                4, 5: begin
                    a = cur_thr + int'($urandom_range(0, 6)) - 3;
                    b = cur_thr + int'($urandom_range(0, 6)) - 3;
                end
                6, 7, 8: begin
                    a = $urandom_range(0, 4095);
                    b = a + int'($urandom_range(0, 2 * cur_tol + 4)) - (cur_tol + 2);
                end
                default: begin
                    a = int'(corner_sample());
                    b = int'(corner_sample());
                end
            endcase
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: ang = 8'd0;
                    1: ang = 8'd180;
                    2: ang = 8'd181;
                    default: ang = 8'd255;
                endcase
            end else begin
                ang = ANGLE_W'($urandom_range(0, 255));
            end
            send_item(act, clamp_sample(a), clamp_sample(b), ang);
        end
    endtask

    initial begin
        #20_000_000;
        $display("** light_tracking_servo_ramp: FAILED **");
        $finish;
    end

    initial begin
        int lo;
        int hi;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        set_profile(0);

        // Directed items at the reset configuration, position 750.
        send_item(ACT_TICK, 12'd0, 12'd0, 8'd0);
        send_item(ACT_UNUSED, 12'd4095, 12'd4095, 8'd255);
        send_item(ACT_ANGLE, 12'd0, 12'd0, 8'd90);
        send_item(ACT_TRACK, 12'd2000, 12'd2000, 8'd0);
        send_item(ACT_TRACK, 12'd3000, 12'd2990, 8'd0);
        send_item(ACT_TRACK, 12'd1000, 12'd1020, 8'd0);
        send_item(ACT_TRACK, 12'd4095, 12'd0, 8'd0);
        send_item(ACT_ANGLE, 12'd0, 12'd0, 8'd0);
        // Split light just above the threshold also counts as balanced; split must win.
        repeat (10) send_item(ACT_TICK, 12'd2049, 12'd2048, 8'd0);
        send_item(ACT_TRACK, 12'd4095, 12'd0, 8'd0);
        repeat (10) send_item(ACT_TICK, 12'd3000, 12'd3010, 8'd0);
        send_random(100, 0);
        drain_results();

        // Narrow range with fast steps so that ramps reach their goals.
        write_reg(REG_PULSE_MIN, 100);
        write_reg(REG_PULSE_MAX, 160);
        write_reg(REG_PULSE_CENTER, 130);
        write_reg(REG_TOLERANCE, 12);
        write_reg(REG_THRESHOLD, 2048);
        write_reg(REG_CHECK_INTVL, 15);
        write_reg(REG_TRACK_TICKS, 1);
        write_reg(REG_ANGLE_TICKS, 1);
        write_reg(REG_UNUSED_LO, 4095);
        write_reg(REG_UNUSED_HI, 0);
        send_random(350, 1);
        drain_results();

        // Reversed pulse range, zero tolerance and threshold, check on every step.
        write_reg(REG_PULSE_MIN, 300);
        write_reg(REG_PULSE_MAX, 200);
        write_reg(REG_PULSE_CENTER, 250);
        write_reg(REG_TOLERANCE, 0);
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_CHECK_INTVL, 1);
        write_reg(REG_TRACK_TICKS, 2);
        write_reg(REG_ANGLE_TICKS, 3);
        send_random(250, 2);
        drain_results();

        // Upper extremes of every register but pulse_min, which is set to zero.
        write_reg(REG_TOLERANCE, 4095);
        write_reg(REG_THRESHOLD, 4095);
        write_reg(REG_PULSE_MIN, 0);
        write_reg(REG_PULSE_MAX, 4095);
        write_reg(REG_PULSE_CENTER, 4095);
        write_reg(REG_CHECK_INTVL, 15);
        write_reg(REG_TRACK_TICKS, 255);
        write_reg(REG_ANGLE_TICKS, 255);
        send_random(200, 3);
        drain_results();

        // Zero interval and zero step ticks behave as one.
        write_reg(REG_PULSE_MIN, 180);
        write_reg(REG_PULSE_MAX, 300);
        write_reg(REG_PULSE_CENTER, 240);
        write_reg(REG_TOLERANCE, 5);
        write_reg(REG_THRESHOLD, 1000);
        write_reg(REG_CHECK_INTVL, 0);
        write_reg(REG_TRACK_TICKS, 0);
        write_reg(REG_ANGLE_TICKS, 0);
        send_random(300, 0);
        drain_results();

        // Random moderate setting.
        lo = $urandom_range(100, 400);
        hi = lo + int'($urandom_range(0, 160)) - 80;
        write_reg(REG_PULSE_MIN, lo);
        write_reg(REG_PULSE_MAX, hi);
        write_reg(REG_PULSE_CENTER, $urandom_range(100, 480));
        write_reg(REG_TOLERANCE, $urandom_range(0, 200));
        write_reg(REG_THRESHOLD, $urandom_range(0, 4095));
        write_reg(REG_CHECK_INTVL, $urandom_range(1, 15));
        write_reg(REG_TRACK_TICKS, $urandom_range(1, 4));
        write_reg(REG_ANGLE_TICKS, $urandom_range(1, 4));
        send_random(300, 1);
        drain_results();

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** light_tracking_servo_ramp: PASSED **");
        end else begin
            $display("** light_tracking_servo_ramp: FAILED **");
        end
        $finish;
    end

endmodule
